// ----- hw/rtl/dif_pkg.sv -----
// ----------------------------------------------------------------------------
// dif_pkg
// Shared constants, codes and control types of the decimal integer formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package dif_pkg;

   // Most characters that one conversion may emit.
   localparam int MAX_CHARS = 64;
   localparam int CNT_W     = $clog2(MAX_CHARS + 1);

   // Operand and decimal register geometry.
   localparam int VALUE_W  = 64;
   localparam int DIGITS   = 20;
   localparam int BCD_W    = 4 * DIGITS;
   localparam int ITER_W   = $clog2(VALUE_W);
   localparam int ND_W     = $clog2(DIGITS + 1);
   localparam int PREC_W   = 6;
   localparam int FW_W     = 7;
   localparam int POS_W    = 8;

   // Conversion kinds.
   localparam logic [1:0] FUNC_SIGNED   = 2'd0;
   localparam logic [1:0] FUNC_UNSIGNED = 2'd1;
   localparam logic [1:0] FUNC_CHAR     = 2'd2;
   localparam logic [1:0] FUNC_NONE     = 2'd3;

   // Operand sizes.
   localparam logic [1:0] SIZE_32 = 2'd0;
   localparam logic [1:0] SIZE_16 = 2'd1;
   localparam logic [1:0] SIZE_64 = 2'd2;

   // Sign modes.
   localparam logic [1:0] SIGN_NONE  = 2'd0;
   localparam logic [1:0] SIGN_SPACE = 2'd1;
   localparam logic [1:0] SIGN_PLUS  = 2'd2;

   // Characters.
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [3:0] DIGIT_HIGH = 4'h3;

   typedef struct packed {
      logic load;
      logic dabble;
      logic trim;
      logic len;
      logic bound;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic dabble_last;
      logic trim_done;
      logic emit_last;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// ----- hw/rtl/dif_if.sv -----
// ----------------------------------------------------------------------------
// dif_if
// Request and response channels of the decimal integer formatter.
// ----------------------------------------------------------------------------
`default_nettype none

interface dif_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [1:0]  size_code;
   logic [63:0] value;
   logic signed [6:0] min_digits;
   logic [6:0]  field_width;
   logic        left_justify;
   logic [1:0]  sign_mode;

   modport source (output valid, func, size_code, value, min_digits, field_width,
                   left_justify, sign_mode, input ready);
   modport sink   (input valid, func, size_code, value, min_digits, field_width,
                   left_justify, sign_mode, output ready);
endinterface

interface dif_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last;

   modport source (output valid, out_char, last, input ready);
   modport sink   (input valid, out_char, last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/dif_ctrl.sv -----
// ----------------------------------------------------------------------------
// dif_ctrl
// Sequencer: accepts a request, runs the binary to decimal conversion, trims
// leading zero digits, lays out the field and steps out the characters.
// ----------------------------------------------------------------------------
`default_nettype none

module dif_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   input  wire [1:0]                req_func,
   output logic                     req_ready,
   output dif_pkg::cmd_type         cmd,
   input  wire dif_pkg::status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_TRIM,
      ST_LEN,
      ST_BOUND,
      ST_EMIT
   } state_type;

   state_type state_ff;
   logic      ready_ff;
   logic      accept;

   assign accept    = req_valid && ready_ff && (state_ff == ST_IDLE);
   assign req_ready = ready_ff;

   always_comb begin
      cmd        = '0;
      cmd.load   = accept;
      unique case (state_ff)
         ST_IDLE:    ;
         ST_CONVERT: cmd.dabble = 1'b1;
         ST_TRIM:    cmd.trim   = !status.trim_done;
         ST_LEN:     cmd.len    = 1'b1;
         ST_BOUND:   cmd.bound  = 1'b1;
         ST_EMIT:    cmd.emit   = status.out_free;
         default:    ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               // A request of the unused kind produces no characters.
               if (accept && (req_func != dif_pkg::FUNC_NONE)) begin
                  state_ff <= ST_CONVERT;
                  ready_ff <= 1'b0;
               end else begin
                  ready_ff <= 1'b1;
               end
            end
            ST_CONVERT: begin
               if (status.dabble_last) state_ff <= ST_TRIM;
            end
            ST_TRIM: begin
               if (status.trim_done) state_ff <= ST_LEN;
            end
            ST_LEN:   state_ff <= ST_BOUND;
            ST_BOUND: state_ff <= ST_EMIT;
            ST_EMIT: begin
               if (status.out_free && status.emit_last) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/dif_datapath.sv -----
// ----------------------------------------------------------------------------
// dif_datapath
// Operand preparation, shift-and-add-3 decimal conversion, digit trimming,
// field layout and the registered character output.
// ----------------------------------------------------------------------------
`default_nettype none

module dif_datapath (
   input  wire                   clock,
   input  wire                   reset,
   input  wire dif_pkg::cmd_type cmd,
   output dif_pkg::status_type   status,
   input  wire [1:0]             req_func,
   input  wire [1:0]             req_size_code,
   input  wire [63:0]            req_value,
   input  wire [6:0]             req_min_digits,
   input  wire [6:0]             req_field_width,
   input  wire                   req_left_justify,
   input  wire [1:0]             req_sign_mode,
   input  wire                   rsp_ready,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_out_char,
   output logic                  rsp_last
);

   logic [dif_pkg::VALUE_W-1:0] bin_ff;
   logic [dif_pkg::BCD_W-1:0]   bcd_ff;
   logic [dif_pkg::ITER_W-1:0]  iter_ff;
   logic [dif_pkg::ND_W-1:0]    nd_ff;
   logic                        is_char_ff;
   logic [7:0]                  char_ff;
   logic [dif_pkg::PREC_W-1:0]  prec_ff;
   logic [dif_pkg::FW_W-1:0]    width_ff;
   logic                        left_ff;
   logic                        sign_len_ff;
   logic [7:0]                  sign_char_ff;
   logic [6:0]                  sz_ff;
   logic [6:0]                  text_len_ff;
   logic [dif_pkg::POS_W-1:0]   b1_ff;
   logic [dif_pkg::POS_W-1:0]   b2_ff;
   logic [dif_pkg::POS_W-1:0]   b3_ff;
   logic [dif_pkg::POS_W-1:0]   b4_ff;
   logic [dif_pkg::CNT_W-1:0]   total_ff;
   logic [dif_pkg::CNT_W-1:0]   k_ff;
   logic                        rsp_valid_ff;
   logic [7:0]                  rsp_char_ff;
   logic                        rsp_last_ff;

   logic                        is_signed;
   logic [dif_pkg::VALUE_W-1:0] v_ext;
   logic                        neg;
   logic [dif_pkg::VALUE_W-1:0] mag;
   logic [dif_pkg::BCD_W-1:0]   bcd_adj;
   logic [dif_pkg::PREC_W-1:0]  zeros_in;
   logic [6:0]                  pad;
   logic [6:0]                  lead;
   logic [dif_pkg::POS_W-1:0]   span;
   logic [dif_pkg::CNT_W-1:0]   total_in;
   logic [dif_pkg::POS_W-1:0]   pos;
   logic [7:0]                  char_in;
   logic [dif_pkg::CNT_W-1:0]   k_next;

   // Operand cut to its size and extended, then split into sign and magnitude.
   always_comb begin
      is_signed = (req_func == dif_pkg::FUNC_SIGNED);
      unique case (req_size_code)
         dif_pkg::SIZE_16: v_ext = {{48{is_signed & req_value[15]}}, req_value[15:0]};
         dif_pkg::SIZE_64: v_ext = req_value;
         default:          v_ext = {{32{is_signed & req_value[31]}}, req_value[31:0]};
      endcase
      neg = is_signed & v_ext[63];
      mag = neg ? (~v_ext + 64'd1) : v_ext;
   end

   // Add 3 to every decimal digit of five or more before the shift.
   always_comb begin
      for (int d = 0; d < dif_pkg::DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] >= 4'd5) bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4] + 4'd3;
         else                         bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4];
      end
   end

   always_comb begin
      if ({1'b0, prec_ff} > 7'(nd_ff)) zeros_in = prec_ff - dif_pkg::PREC_W'(nd_ff);
      else                             zeros_in = '0;
   end

   always_comb begin
      if (width_ff > text_len_ff) pad = width_ff - text_len_ff;
      else                        pad = '0;
      lead = left_ff ? 7'd0 : pad;
      span = {1'b0, pad} + {1'b0, text_len_ff};
      if (span > dif_pkg::POS_W'(dif_pkg::MAX_CHARS))
         total_in = dif_pkg::CNT_W'(dif_pkg::MAX_CHARS);
      else
         total_in = span[dif_pkg::CNT_W-1:0];
   end

   // Character at the current field position.
   always_comb begin
      pos = dif_pkg::POS_W'(k_ff);
      priority if (pos < b1_ff) char_in = dif_pkg::CHAR_SPACE;
      else if (pos < b2_ff)     char_in = sign_char_ff;
      else if (pos < b3_ff)     char_in = dif_pkg::CHAR_ZERO;
      else if (pos < b4_ff)     char_in = is_char_ff ? char_ff
                                          : {dif_pkg::DIGIT_HIGH, bcd_ff[dif_pkg::BCD_W-1 -: 4]};
      else                      char_in = dif_pkg::CHAR_SPACE;
   end

   assign k_next = k_ff + dif_pkg::CNT_W'(1);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         bin_ff     <= mag;
         bcd_ff     <= '0;
         iter_ff    <= '0;
         nd_ff      <= dif_pkg::ND_W'(dif_pkg::DIGITS);
         is_char_ff <= (req_func == dif_pkg::FUNC_CHAR);
         char_ff    <= req_value[7:0];
         prec_ff    <= req_min_digits[6] ? '0 : req_min_digits[5:0];
         width_ff   <= req_field_width;
         left_ff    <= req_left_justify;
         if (!is_signed) begin
            sign_len_ff  <= 1'b0;
            sign_char_ff <= dif_pkg::CHAR_SPACE;
         end else if (neg) begin
            sign_len_ff  <= 1'b1;
            sign_char_ff <= dif_pkg::CHAR_MINUS;
         end else if (req_sign_mode >= dif_pkg::SIGN_PLUS) begin
            sign_len_ff  <= 1'b1;
            sign_char_ff <= dif_pkg::CHAR_PLUS;
         end else if (req_sign_mode == dif_pkg::SIGN_SPACE) begin
            sign_len_ff  <= 1'b1;
            sign_char_ff <= dif_pkg::CHAR_SPACE;
         end else begin
            sign_len_ff  <= 1'b0;
            sign_char_ff <= dif_pkg::CHAR_SPACE;
         end
      end
      if (cmd.dabble) begin
         bcd_ff  <= {bcd_adj[dif_pkg::BCD_W-2:0], bin_ff[dif_pkg::VALUE_W-1]};
         bin_ff  <= {bin_ff[dif_pkg::VALUE_W-2:0], 1'b0};
         iter_ff <= iter_ff + dif_pkg::ITER_W'(1);
      end
      if (cmd.trim) begin
         bcd_ff <= {bcd_ff[dif_pkg::BCD_W-5:0], 4'h0};
         nd_ff  <= nd_ff - dif_pkg::ND_W'(1);
      end
      if (cmd.len) begin
         if (is_char_ff) begin
            sz_ff       <= '0;
            text_len_ff <= 7'd1;
         end else begin
            sz_ff       <= 7'(sign_len_ff) + 7'(zeros_in);
            text_len_ff <= 7'(sign_len_ff) + 7'(zeros_in) + 7'(nd_ff);
         end
      end
      if (cmd.bound) begin
         b1_ff    <= dif_pkg::POS_W'(lead);
         b2_ff    <= dif_pkg::POS_W'(lead) + dif_pkg::POS_W'(sign_len_ff);
         b3_ff    <= dif_pkg::POS_W'(lead) + dif_pkg::POS_W'(sz_ff);
         b4_ff    <= dif_pkg::POS_W'(lead) + dif_pkg::POS_W'(text_len_ff);
         total_ff <= total_in;
         k_ff     <= '0;
      end
      if (cmd.emit) begin
         rsp_char_ff <= char_in;
         rsp_last_ff <= (k_next == total_ff);
         k_ff        <= k_next;
         // Digits leave from the top of the decimal register.
         if (!is_char_ff && (pos >= b3_ff) && (pos < b4_ff))
            bcd_ff <= {bcd_ff[dif_pkg::BCD_W-5:0], 4'h0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.dabble_last = (iter_ff == {dif_pkg::ITER_W{1'b1}});
   assign status.trim_done   = (nd_ff == dif_pkg::ND_W'(1))
                               || (bcd_ff[dif_pkg::BCD_W-1 -: 4] != 4'h0);
   assign status.emit_last   = (k_next == total_ff);
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/decimal_integer_formatter.sv -----
// ----------------------------------------------------------------------------
// decimal_integer_formatter
// Formats one integer or character request as a padded decimal text field.
// ----------------------------------------------------------------------------
// Sequence: once a request is taken, 64 shift-and-add-3 steps, up to 19 trims
// of leading zeros and the layout states ST_LEN and ST_BOUND run, then emission.
// Throughput: then one character per cycle, up to 64 per request, while the
// response side keeps up; the next request waits for the last character.
// Reset: synchronous; the channel is idle and turns ready in the cycle after reset.
`default_nettype none

module decimal_integer_formatter (
   input  wire       clock,
   input  wire       reset,
   dif_req_if.sink   req_chan,
   dif_rsp_if.source rsp_chan
);

   dif_pkg::cmd_type    cmd;
   dif_pkg::status_type status;

   dif_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_func  (req_chan.func),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   dif_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_func         (req_chan.func),
      .req_size_code    (req_chan.size_code),
      .req_value        (req_chan.value),
      .req_min_digits   (req_chan.min_digits),
      .req_field_width  (req_chan.field_width),
      .req_left_justify (req_chan.left_justify),
      .req_sign_mode    (req_chan.sign_mode),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_out_char     (rsp_chan.out_char),
      .rsp_last         (rsp_chan.last)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/dif_checker.sv -----
// ----------------------------------------------------------------------------
// dif_checker
// Port-level checks of the decimal integer formatter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dif_checker (
   input wire       clock,
   input wire       reset,
   input wire       req_valid,
   input wire       req_ready,
   input wire [1:0] req_func,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire [7:0] rsp_out_char,
   input wire       rsp_last
);

   // A stalled character holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char) && $stable(rsp_last))
      else $error("response changed while stalled");

   // A request that produces text keeps the request side closed while it converts.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_func != dif_pkg::FUNC_NONE)
      |=> !req_ready ##1 !req_ready ##1 !req_ready)
      else $error("new request taken during a conversion");

   // While a new request may enter, only the final character can still wait.
   a_ready_last: assert property (@(posedge clock) disable iff (reset)
      req_ready && rsp_valid |-> rsp_last)
      else $error("request side open with characters outstanding");

   // Characters are only produced while a conversion is in progress.
   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("character produced while idle");

endmodule

bind decimal_integer_formatter dif_checker u_dif_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .req_func     (req_chan.func),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_out_char (rsp_chan.out_char),
   .rsp_last     (rsp_chan.last)
);

`default_nettype wire

// ----- test/decimal_integer_formatter_tb.sv -----
// ----------------------------------------------------------------------------
// decimal_integer_formatter_tb
// Self-checking bench for the decimal integer formatter. A queue of requests,
// directed corner cases first and then random conversions, feeds a clocked
// driver; a clocked monitor compares every emitted character and its last flag
// with the field predicted for each accepted request. Both channels idle at
// random.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_integer_formatter_tb;
   import dif_pkg::*;

   // Codes that the package leaves unnamed but the block must still accept.
   localparam logic [1:0] SIZE_SPARE      = 2'd3;
   localparam logic [1:0] SIGN_PLUS_SPARE = 2'd3;

   localparam int RANDOM_REQUESTS = 157;
   localparam int CYCLE_LIMIT     = 3_000_000;
   localparam int TAIL_CYCLES     = 200;

   typedef struct {
      logic [1:0]        func;
      logic [1:0]        size_code;
      logic [63:0]       value;
      logic signed [6:0] min_digits;
      logic [6:0]        field_width;
      logic              left_justify;
      logic [1:0]        sign_mode;
   } conv_req_type;

   typedef struct {
      conv_req_type req;
      int           gap;
      bit           drain;
   } queued_req_type;

   typedef struct {
      logic [7:0] ch;
      logic       last;
   } field_char_type;

   logic clock = 1'b0;
   logic reset;

   dif_req_if req_if ();
   dif_rsp_if rsp_if ();

   decimal_integer_formatter dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   queued_req_type pending_reqs[$];
   field_char_type expected_chars[$];
   conv_req_type   presented;

   int errors          = 0;
   int reqs_taken      = 0;
   int chars_checked   = 0;
   int truncated_fields = 0;
   int kind_count[4]   = '{0, 0, 0, 0};
   int idle_count      = 0;
   int stall_left      = 0;
   int stall_mode      = 0;
   int cycles          = 0;

   // Builds the formatted field of one request and queues its characters.
   function automatic void format_field(input conv_req_type r);
      logic [7:0]     text[$];
      logic [7:0]     digs[$];
      logic [7:0]     field[$];
      logic [63:0]    v;
      logic [63:0]    mag;
      logic           is_signed;
      logic           neg;
      int             prec;
      int             pad;
      int             n;
      field_char_type fc;

      kind_count[r.func]++;
      if (r.func == FUNC_NONE)
         return;
      if (r.func == FUNC_CHAR) begin
         text.push_back(r.value[7:0]);
      end else begin
         is_signed = (r.func == FUNC_SIGNED);
         v = r.value;
         case (r.size_code)
            SIZE_16: v = is_signed ? {{48{v[15]}}, v[15:0]} : {48'd0, v[15:0]};
            SIZE_64: ;
            default: v = is_signed ? {{32{v[31]}}, v[31:0]} : {32'd0, v[31:0]};
         endcase
         neg = is_signed && v[63];
         // The most negative value wraps back onto itself, which is the
         // correct unsigned magnitude.
         mag = neg ? (64'd0 - v) : v;
         do begin
            digs.push_front(CHAR_ZERO + 8'(mag % 64'd10));
            mag = mag / 64'd10;
         end while (mag != 64'd0);
         // A negative precision means none.
         prec = r.min_digits[6] ? 0 : int'(r.min_digits[5:0]);
         if (is_signed) begin
            if (neg)
               text.push_back(CHAR_MINUS);
            else if (r.sign_mode >= SIGN_PLUS)
               text.push_back(CHAR_PLUS);
            else if (r.sign_mode == SIGN_SPACE)
               text.push_back(CHAR_SPACE);
         end
         for (int i = digs.size(); i < prec && text.size() < MAX_CHARS; i++)
            text.push_back(CHAR_ZERO);
         foreach (digs[i])
            if (text.size() < MAX_CHARS)
               text.push_back(digs[i]);
      end
      pad = (int'(r.field_width) > text.size()) ? int'(r.field_width) - text.size() : 0;
      if (!r.left_justify)
         repeat (pad) field.push_back(CHAR_SPACE);
      foreach (text[i])
         field.push_back(text[i]);
      if (r.left_justify)
         repeat (pad) field.push_back(CHAR_SPACE);
      n = field.size();
      if (n > MAX_CHARS) begin
         truncated_fields++;
         n = MAX_CHARS;
      end
      for (int i = 0; i < n; i++) begin
         fc.ch   = field[i];
         fc.last = (i == n - 1);
         expected_chars.push_back(fc);
      end
   endfunction

   // Mostly short gaps, now and then a long one; none in a calm stretch.
   function automatic int pick_gap(input bit calm);
      int r;

      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 88)
         return $urandom_range(1, 4);
      return $urandom_range(20, 80);
   endfunction

   function automatic conv_req_type random_request();
      conv_req_type r;
      logic [63:0] edges[8];

      edges = '{64'h7FFF_FFFF, 64'h8000_0000, 64'hFFFF_FFFF, 64'h7FFF, 64'h8000,
                64'hFFFF, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF};
      r.func      = ($urandom_range(0, 29) == 0) ? FUNC_NONE : 2'($urandom_range(0, 2));
      r.size_code = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 5))
         0: r.value = {$urandom, $urandom};
         1: r.value = 64'($urandom_range(0, 999));
         2: r.value = edges[$urandom_range(0, 7)] + 64'($urandom_range(0, 2)) - 64'd1;
         3: r.value = {{32{1'b1}}, 32'($urandom)};
         4: r.value = {32'($urandom), 16'($urandom), 16'($urandom)};
         default: r.value = 64'($urandom_range(0, 9));
      endcase
      case ($urandom_range(0, 9))
         0, 1, 2, 3: r.min_digits = -7'sd1;
         4, 5, 6, 7: r.min_digits = 7'($urandom_range(0, 40));
         8: r.min_digits = 7'($urandom);
         default: r.min_digits = 7'($urandom_range(0, 3));
      endcase
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: r.field_width = 7'($urandom_range(0, 24));
         6, 7: r.field_width = 7'd0;
         8: r.field_width = 7'($urandom_range(25, 64));
         default: r.field_width = 7'($urandom);
      endcase
      r.left_justify = 1'($urandom);
      r.sign_mode    = 2'($urandom);
      return r;
   endfunction

   task automatic queue_request(input logic [1:0] func, input logic [1:0] size_code,
                                input logic [63:0] value, input logic signed [6:0] md,
                                input logic [6:0] fw, input logic left,
                                input logic [1:0] smode);
      queued_req_type q;

      q.req = '{func, size_code, value, md, fw, left, smode};
      q.gap = pick_gap(1'b0);
      q.drain = 1'b0;
      pending_reqs.push_back(q);
   endtask

   // Request driver: presents the head of the queue once its gap has passed.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         idle_count = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            format_field(presented);
            reqs_taken++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_reqs.size() > 0 && idle_count >= pending_reqs[0].gap &&
                (!pending_reqs[0].drain || expected_chars.size() == 0)) begin
               presented = pending_reqs.pop_front().req;
               req_if.valid        <= 1'b1;
               req_if.func         <= presented.func;
               req_if.size_code    <= presented.size_code;
               req_if.value        <= presented.value;
               req_if.min_digits   <= presented.min_digits;
               req_if.field_width  <= presented.field_width;
               req_if.left_justify <= presented.left_justify;
               req_if.sign_mode    <= presented.sign_mode;
               idle_count = 0;
            end else begin
               req_if.valid <= 1'b0;
               idle_count++;
            end
         end
      end
   end

   // Response monitor with random back-pressure in changing moods.
   always @(posedge clock) begin
      field_char_type exp_c;

      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_chars.size() == 0) begin
               $error("unexpected character: out_char %h last %b", rsp_if.out_char,
                      rsp_if.last);
               errors++;
            end else begin
               exp_c = expected_chars.pop_front();
               chars_checked++;
               if (rsp_if.out_char !== exp_c.ch) begin
                  $error("out_char: expected %h, actual %h", exp_c.ch, rsp_if.out_char);
                  errors++;
               end
               if (rsp_if.last !== exp_c.last) begin
                  $error("last: expected %b, actual %b", exp_c.last, rsp_if.last);
                  errors++;
               end
            end
         end
         if (cycles % 256 == 0)
            stall_mode = $urandom_range(0, 2);
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
            if (stall_mode != 0) begin
               case ($urandom_range(0, 99)) inside
                  [0:14]:  stall_left = $urandom_range(1, 3);
                  [15:16]: stall_left = $urandom_range(8, 30);
                  default: stall_left = 0;
               endcase
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      bit calm;
      queued_req_type q;

      reset = 1'b1;
      req_if.valid        = 1'b0;
      req_if.func         = FUNC_SIGNED;
      req_if.size_code    = SIZE_32;
      req_if.value        = '0;
      req_if.min_digits   = '0;
      req_if.field_width  = '0;
      req_if.left_justify = 1'b0;
      req_if.sign_mode    = SIGN_NONE;
      rsp_if.ready        = 1'b0;

      // Zero with no digits asked for still prints one digit.
      queue_request(FUNC_SIGNED,   SIZE_32, 64'd0, 7'sd0, 7'd0, 1'b0, SIGN_NONE);
      queue_request(FUNC_UNSIGNED, SIZE_64, 64'd0, -7'sd1, 7'd0, 1'b0, SIGN_NONE);
      queue_request(FUNC_SIGNED,   SIZE_64, 64'd0, 7'sd0, 7'd0, 1'b0, SIGN_PLUS);
      queue_request(FUNC_UNSIGNED, SIZE_32, 64'd0, 7'sd0, 7'd1, 1'b0, SIGN_NONE);
      // Most negative values at each size, garbage above the narrower ones, then other extremes.
      queue_request(FUNC_SIGNED, SIZE_32, 64'h1234_5678_8000_0000, -7'sd1, 7'd0, 1'b0,
                    SIGN_NONE);
      queue_request(FUNC_SIGNED, SIZE_64, 64'h8000_0000_0000_0000, -7'sd1, 7'd24, 1'b0,
                    SIGN_PLUS);
      queue_request(FUNC_SIGNED, SIZE_16, 64'hABCD_EF01_2345_8000, 7'sd8, 7'd12, 1'b1,
                    SIGN_SPACE);
      queue_request(FUNC_UNSIGNED, SIZE_64, '1, 7'sd40, 7'd64, 1'b1, SIGN_PLUS);
      queue_request(FUNC_UNSIGNED, SIZE_16, '1, 7'sd63, 7'd0, 1'b0, SIGN_NONE);
      queue_request(FUNC_SIGNED, SIZE_64, 64'h7FFF_FFFF_FFFF_FFFF, 7'sd20, 7'd30, 1'b0,
                    SIGN_PLUS);
      queue_request(FUNC_SIGNED, SIZE_32, 64'd12345, 7'sh40, 7'd10, 1'b0, SIGN_SPACE);
      queue_request(FUNC_SIGNED, SIZE_SPARE, 64'hFFFF_FFFF_FFFF_FFFE, 7'sd5, 7'd0, 1'b0,
                    SIGN_PLUS);
      queue_request(FUNC_SIGNED, SIZE_32, 64'd42, -7'sd1, 7'd0, 1'b0, SIGN_PLUS_SPARE);
      queue_request(FUNC_NONE, SIZE_32, 64'd77, 7'sd3, 7'd20, 1'b0, SIGN_PLUS);
      // A NUL character still counts as one character.
      queue_request(FUNC_CHAR, SIZE_32, 64'd0, -7'sd1, 7'd5, 1'b1, SIGN_NONE);
      queue_request(FUNC_CHAR, SIZE_64, '1, 7'sd40, 7'd3, 1'b0, SIGN_PLUS);
      queue_request(FUNC_CHAR, SIZE_16, 64'h41, 7'sd0, 7'd0, 1'b0, SIGN_SPACE);
      // Fields longer than the block can emit.
      queue_request(FUNC_SIGNED, SIZE_64, '1, 7'sd40, 7'd127, 1'b0, SIGN_NONE);
      queue_request(FUNC_SIGNED, SIZE_64, 64'h8000_0000_0000_0000, 7'sd40, 7'd127, 1'b1,
                    SIGN_NONE);
      queue_request(FUNC_CHAR, SIZE_32, 64'd0, -7'sd1, 7'd127, 1'b0, SIGN_NONE);
      queue_request(FUNC_SIGNED, SIZE_16, 64'h7FFF, -7'sd1, 7'd3, 1'b1, SIGN_SPACE);
      queue_request(FUNC_UNSIGNED, SIZE_32, 64'hFFFF_FFFF_0000_0000, -7'sd1, 7'd0, 1'b0,
                    SIGN_NONE);
      queue_request(FUNC_NONE, SIZE_64, 64'd0, 7'sd0, 7'd0, 1'b0, SIGN_NONE);

      calm = 1'b0;
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if (i % 16 == 0)
            calm = ($urandom_range(0, 3) == 0);
         q.req   = random_request();
         q.gap   = pick_gap(calm);
         // Hold the sender back until the block has emptied, now and then.
         q.drain = (i == 0) || ($urandom_range(0, 39) == 0);
         pending_reqs.push_back(q);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_if.valid)
         @(posedge clock);
      while (expected_chars.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d requests taken (signed %0d, unsigned %0d, character %0d, unused %0d)",
               reqs_taken, kind_count[FUNC_SIGNED], kind_count[FUNC_UNSIGNED],
               kind_count[FUNC_CHAR], kind_count[FUNC_NONE]);
      $display("%0d characters checked, %0d fields cut at the character limit",
               chars_checked, truncated_fields);
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire

// ----- filelist.f -----
hw/rtl/dif_pkg.sv
hw/rtl/dif_if.sv
hw/rtl/dif_ctrl.sv
hw/rtl/dif_datapath.sv
hw/rtl/decimal_integer_formatter.sv
hw/rtl/dif_checker.sv
test/decimal_integer_formatter_tb.sv
